@@ src/snaw_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// snaw_pkg
// Types and constants of the strided N-dimensional address walker.
// ----------------------------------------------------------------------------
package snaw_pkg;

    localparam int LANE_W     = 16;
    localparam int LANE_COUNT = 4;
    localparam int CFG_W      = 64;
    localparam int DATA_W     = 32;
    localparam int SUM_W      = 35;

    localparam logic [CFG_W-1:0] SIZES_RESET   = 64'h0001_0001_0001_0001;
    localparam logic [CFG_W-1:0] STRIDES_RESET = 64'h0000_0000_0000_0001;

    typedef enum logic [1:0] {
        MODE_GATHER  = 2'd0,
        MODE_SCATTER = 2'd1,
        MODE_FILL    = 2'd2
    } walk_mode_t;

    typedef enum logic [1:0] {
        CFG_WALK_MODE   = 2'd0,
        CFG_BASE_OFFSET = 2'd1,
        CFG_DIM_SIZES   = 2'd2,
        CFG_DIM_STRIDES = 2'd3
    } cfg_index_t;

endpackage

`default_nettype wire

@@ src/strided_nd_address_walker_top.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// strided_nd_address_walker_top
// Address generator for gather, scatter and fill over a strided array view.
// ----------------------------------------------------------------------------
// Every input transfer asks for the next element of the walk and yields one
// result transfer with a read address, a write address and flags. The block
// takes one item per clock while the output is not held. For each item the
// index counters advance in the accept cycle, the stride products are
// registered in the second stage, and the sum with the base offset and the
// mode selection fill the output register in the third.
// Each stage holds its item only while the next one is full, so up to two
// further input transfers are taken while a result waits at the output.
// ----------------------------------------------------------------------------
module strided_nd_address_walker_top
    import snaw_pkg::*;
#(
    parameter int MAX_DIMS   = 4,
    parameter int ADDR_WIDTH = 32
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [1:0]        cfg_index,
    input  wire logic [CFG_W-1:0]  cfg_wdata,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              restart,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      read_addr,
    output logic [DATA_W-1:0]      write_addr,
    output logic                   write_scalar,
    output logic                   addr_overflow,
    output logic                   last
);

    localparam int STRIDED_DIMS = (MAX_DIMS < LANE_COUNT) ? MAX_DIMS : LANE_COUNT;
    localparam int MASK_BITS    = (ADDR_WIDTH < SUM_W) ? ADDR_WIDTH : SUM_W;
    localparam logic [SUM_W-1:0] ADDR_MASK = {SUM_W{1'b1}} >> (SUM_W - MASK_BITS);

    walk_mode_t              walk_mode_reg;
    logic [DATA_W-1:0]       base_offset_reg;
    logic [CFG_W-1:0]        dim_sizes_reg;
    logic [CFG_W-1:0]        dim_strides_reg;

    logic [LANE_W-1:0]       dim_index_reg [MAX_DIMS];
    logic [LANE_W-1:0]       dim_index_next [MAX_DIMS];
    logic [DATA_W-1:0]       lin_reg;
    logic [DATA_W-1:0]       lin_next;

    logic [LANE_W-1:0]       size_lane [MAX_DIMS];
    logic [LANE_W-1:0]       stride_lane [STRIDED_DIMS];
    logic [LANE_W-1:0]       idx_cur [MAX_DIMS];
    logic [LANE_W-1:0]       size_eff [MAX_DIMS];
    logic [MAX_DIMS-1:0]     at_end;
    logic [DATA_W-1:0]       lin_cur;
    logic                    walk_last;
    logic                    lower_done;
    logic                    in_xfer;

    logic                    s1_valid_reg;
    logic [LANE_W-1:0]       s1_idx_reg [STRIDED_DIMS];
    logic [DATA_W-1:0]       s1_lin_reg;
    logic                    s1_last_reg;

    logic                    s2_valid_reg;
    logic [2*LANE_W-1:0]     s2_prod_reg [STRIDED_DIMS];
    logic [DATA_W-1:0]       s2_lin_reg;
    logic                    s2_last_reg;

    logic                    out_valid_reg;
    logic [DATA_W-1:0]       read_addr_reg;
    logic [DATA_W-1:0]       write_addr_reg;
    logic                    write_scalar_reg;
    logic                    addr_overflow_reg;
    logic                    last_reg;

    logic                    ready2;
    logic                    ready3;
    logic [SUM_W-1:0]        strided_sum;
    logic [DATA_W-1:0]       strided_addr;
    logic [DATA_W-1:0]       read_addr_next;
    logic [DATA_W-1:0]       write_addr_next;
    logic                    write_scalar_next;

    for (genvar g = 0; g < MAX_DIMS; g++) begin : g_size
        if (g < LANE_COUNT) begin : g_cfg
            assign size_lane[g] = dim_sizes_reg[g*LANE_W +: LANE_W];
        end
        else begin : g_unit
            assign size_lane[g] = '0;
        end
    end

    for (genvar g = 0; g < STRIDED_DIMS; g++) begin : g_stride
        assign stride_lane[g] = dim_strides_reg[g*LANE_W +: LANE_W];
    end

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            walk_mode_reg   <= MODE_GATHER;
            base_offset_reg <= '0;
            dim_sizes_reg   <= SIZES_RESET;
            dim_strides_reg <= STRIDES_RESET;
        end
        else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_WALK_MODE:   walk_mode_reg   <= walk_mode_t'(cfg_wdata[1:0]);
                CFG_BASE_OFFSET: base_offset_reg <= cfg_wdata[DATA_W-1:0];
                CFG_DIM_SIZES:   dim_sizes_reg   <= cfg_wdata;
                CFG_DIM_STRIDES: dim_strides_reg <= cfg_wdata;
                default:         walk_mode_reg   <= walk_mode_reg;
            endcase
        end
    end

    // Index counters: the innermost dimension counts fastest and carries out
    // when it reaches its end.
    always_comb
    begin
        lin_cur    = restart ? '0 : lin_reg;
        lower_done = 1'b1;
        for (int d = 0; d < MAX_DIMS; d++) begin
            idx_cur[d]  = restart ? '0 : dim_index_reg[d];
            size_eff[d] = (size_lane[d] == '0) ? LANE_W'(1) : size_lane[d];
            at_end[d]   = !(({1'b0, idx_cur[d]} + 1'b1) < {1'b0, size_eff[d]});
        end
        walk_last = &at_end;
        for (int d = 0; d < MAX_DIMS; d++) begin
            dim_index_next[d] = idx_cur[d];
            if (walk_last) begin
                dim_index_next[d] = '0;
            end
            else if (lower_done) begin
                if (at_end[d]) begin
                    dim_index_next[d] = '0;
                end
                else begin
                    dim_index_next[d] = idx_cur[d] + 1'b1;
                end
            end
            lower_done = lower_done & at_end[d];
        end
        lin_next = walk_last ? '0 : lin_cur + 1'b1;
    end

    assign ready3   = !out_valid_reg || out_ready;
    assign ready2   = !s2_valid_reg || ready3;
    assign in_ready = !s1_valid_reg || ready2;
    assign in_xfer  = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            lin_reg <= '0;
            for (int d = 0; d < MAX_DIMS; d++) begin
                dim_index_reg[d] <= '0;
            end
        end
        else if (in_xfer) begin
            lin_reg <= lin_next;
            for (int d = 0; d < MAX_DIMS; d++) begin
                dim_index_reg[d] <= dim_index_next[d];
            end
        end
    end

    // Pipeline valid bits.
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (in_ready) begin
                s1_valid_reg <= in_valid;
            end
            if (ready2) begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (ready3) begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

    // Stage one holds the index snapshot of the element.
    always_ff @(posedge clk) begin
        if (in_xfer) begin
            s1_lin_reg  <= lin_cur;
            s1_last_reg <= walk_last;
            for (int d = 0; d < STRIDED_DIMS; d++) begin
                s1_idx_reg[d] <= idx_cur[d];
            end
        end
    end

    // Stage two holds the stride products.
    always_ff @(posedge clk) begin
        if (ready2 && s1_valid_reg) begin
            s2_lin_reg  <= s1_lin_reg;
            s2_last_reg <= s1_last_reg;
            for (int d = 0; d < STRIDED_DIMS; d++) begin
                s2_prod_reg[d] <= stride_lane[d] * s1_idx_reg[d];
            end
        end
    end

    always_comb
    begin
        strided_sum = SUM_W'(base_offset_reg);
        for (int d = 0; d < STRIDED_DIMS; d++) begin
            strided_sum = strided_sum + SUM_W'(s2_prod_reg[d]);
        end
        strided_addr = DATA_W'(strided_sum & ADDR_MASK);
        case (walk_mode_reg)
            MODE_GATHER:
            begin
                read_addr_next    = strided_addr;
                write_addr_next   = s2_lin_reg;
                write_scalar_next = 1'b0;
            end
            MODE_SCATTER:
            begin
                read_addr_next    = s2_lin_reg;
                write_addr_next   = strided_addr;
                write_scalar_next = 1'b0;
            end
            default:
            begin
                read_addr_next    = '0;
                write_addr_next   = strided_addr;
                write_scalar_next = 1'b1;
            end
        endcase
    end

    // Output register.
    always_ff @(posedge clk) begin
        if (ready3 && s2_valid_reg) begin
            read_addr_reg     <= read_addr_next;
            write_addr_reg    <= write_addr_next;
            write_scalar_reg  <= write_scalar_next;
            addr_overflow_reg <= |(strided_sum & ~ADDR_MASK);
            last_reg          <= s2_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign read_addr     = read_addr_reg;
    assign write_addr    = write_addr_reg;
    assign write_scalar  = write_scalar_reg;
    assign addr_overflow = addr_overflow_reg;
    assign last          = last_reg;

`ifndef SYNTH
    // The final element of a walk leaves the counters at zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && walk_last |=> (lin_reg == '0) && (dim_index_reg[0] == '0))
        else $error("counters not cleared after the final element");

    // Any other element advances the element counter by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_xfer && !walk_last |=> lin_reg == $past(lin_cur) + 1'b1)
        else $error("element counter did not advance");

    // A fill result never carries a read address.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && write_scalar |-> read_addr == '0)
        else $error("fill result with a nonzero read address");
`endif

endmodule

`default_nettype wire
